// ===== design/cmhp_pkg.sv =====
// ----------------------------------------------------------------------------
// cmhp_pkg
// Types and constants shared by the CoAP message header parser. This covers
// the transaction structs of the byte and result channels, the sizes and the
// status codes.
// ----------------------------------------------------------------------------
package cmhp_pkg;

	localparam int MAX_MESSAGE_BYTES = 1024;
	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int OFF_W = 11;
	localparam int CALC_W = (POS_W > OFF_W) ? POS_W : OFF_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_URI_PATH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_URI_QUERY = 1'd1;

	localparam logic [7:0] URI_PATH_RESET = 8'd9;
	localparam logic [7:0] URI_QUERY_RESET = 8'd15;

	localparam logic [3:0] EXT_LEN_NIBBLE = 4'hF;
	localparam logic [7:0] QUESTION_MARK = 8'h3F;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNCATED = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} cmhp_in_t;

	typedef struct packed {
		logic [1:0]       version;
		logic [1:0]       msg_type;
		logic [3:0]       option_total;
		logic [7:0]       code;
		logic [15:0]      transaction_id;
		logic [OFF_W-1:0] uri_offset;
		logic [OFF_W-1:0] uri_len;
		logic [OFF_W-1:0] query_offset;
		logic [OFF_W-1:0] query_bytes;
		logic [OFF_W-1:0] payload_offset;
		logic [OFF_W-1:0] payload_bytes;
		logic [1:0]       status;
	} cmhp_out_t;

endpackage

// ===== design/coap_message_header_parser.sv =====
// ----------------------------------------------------------------------------
// coap_message_header_parser
// Streaming parser for early-draft CoAP messages. It takes one byte per
// transaction and returns one summary result on the byte flagged last.
// ----------------------------------------------------------------------------
// Channel   Signals                               Direction
// byte      byte_valid, byte_ready, byte_data     in
// result    result_valid, result_ready, result    out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// One byte is taken per cycle while the byte channel does not stall. A byte is
// held in the byte register and parsed in one pass as it leaves it; for a last
// byte the same edge loads the result register, which then holds the result.
// Reset clears the message state and loads the option numbers 9 and 15.
// The byte channel stalls only while a last byte waits in the byte register
// for an earlier result to be taken.
// ----------------------------------------------------------------------------
module coap_message_header_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_ready,
	input  cmhp_pkg::cmhp_in_t                byte_data,
	output logic                              result_valid,
	input  logic                              result_ready,
	output cmhp_pkg::cmhp_out_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cmhp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);
	import cmhp_pkg::*;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_OPT_HEAD = 3'd1;
	localparam logic [2:0] PH_OPT_EXT = 3'd2;
	localparam logic [2:0] PH_OPT_VAL = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_URI = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	logic [7:0] uri_path_num_q;
	logic [7:0] uri_query_num_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;

	logic [POS_W-1:0] pos_q, nx_pos;
	logic [2:0]       phase_q, nx_phase;
	logic [31:0]      hdr_q, nx_hdr;
	logic [3:0]       opts_q, nx_opts;
	logic [7:0]       run_q, nx_run;
	logic [8:0]       left_q, nx_left;
	logic [1:0]       kind_q, nx_kind;
	logic             uri_vld_q, nx_uri_vld;
	logic [POS_W-1:0] uri_off_q, nx_uri_off;
	logic [8:0]       uri_len_q, nx_uri_len;
	logic             qry_vld_q, nx_qry_vld;
	logic [POS_W-1:0] qry_off_q, nx_qry_off;
	logic [8:0]       qry_len_q, nx_qry_len;
	logic             qm_found_q, nx_qm_found;
	logic [POS_W-1:0] qm_pos_q, nx_qm_pos;
	logic [POS_W-1:0] pstart_q, nx_pstart;
	logic             too_long_q, nx_too_long;

	logic [POS_W-1:0] pos_inc;
	logic [7:0]       run_head;
	logic             sv_go;
	logic [8:0]       sv_len;
	logic             fin_go;

	logic [CALC_W-1:0] c_uri_off, c_uri_len, c_qm_pos, c_ul, c_ql, c_pos, c_ps;
	cmhp_out_t         res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uri_path_num_q <= URI_PATH_RESET;
			uri_query_num_q <= URI_QUERY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_URI_PATH: uri_path_num_q <= cfg_data;
				REG_URI_QUERY: uri_query_num_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!last_s1 || !result_valid || result_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= byte_data.data_byte;
			last_s1 <= byte_data.last_byte;
		end
	end

	assign pos_inc = pos_q + POS_W'(1);
	assign run_head = run_q + {4'b0000, data_s1[7:4]};

	always_comb begin
		nx_pos = pos_q;
		nx_phase = phase_q;
		nx_hdr = hdr_q;
		nx_opts = opts_q;
		nx_run = run_q;
		nx_left = left_q;
		nx_kind = kind_q;
		nx_uri_vld = uri_vld_q;
		nx_uri_off = uri_off_q;
		nx_uri_len = uri_len_q;
		nx_qry_vld = qry_vld_q;
		nx_qry_off = qry_off_q;
		nx_qry_len = qry_len_q;
		nx_qm_found = qm_found_q;
		nx_qm_pos = qm_pos_q;
		nx_pstart = pstart_q;
		nx_too_long = too_long_q;
		sv_go = 1'b0;
		sv_len = '0;
		fin_go = 1'b0;
		if (pos_q >= POS_W'(MAX_MESSAGE_BYTES)) begin
			nx_too_long = 1'b1;
		end else begin
			nx_pos = pos_inc;
			unique case (phase_q)
				PH_HEADER: begin
					unique case (pos_q[1:0])
						2'd0: nx_hdr[31:24] = data_s1;
						2'd1: nx_hdr[23:16] = data_s1;
						2'd2: nx_hdr[15:8] = data_s1;
						default: nx_hdr[7:0] = data_s1;
					endcase
					if (pos_q >= POS_W'(3)) begin
						nx_opts = hdr_q[27:24];
						nx_run = '0;
						if (hdr_q[27:24] != 4'd0) begin
							nx_phase = PH_OPT_HEAD;
						end else begin
							nx_phase = PH_PAYLOAD;
							nx_pstart = POS_W'(4);
						end
					end
				end
				PH_OPT_HEAD: begin
					nx_run = run_head;
					if (data_s1[3:0] == EXT_LEN_NIBBLE) begin
						nx_phase = PH_OPT_EXT;
					end else begin
						sv_go = 1'b1;
						sv_len = {5'b00000, data_s1[3:0]};
					end
				end
				PH_OPT_EXT: begin
					sv_go = 1'b1;
					sv_len = {5'b00000, EXT_LEN_NIBBLE} + {1'b0, data_s1};
				end
				PH_OPT_VAL: begin
					if (kind_q == KIND_URI && !qm_found_q && data_s1 == QUESTION_MARK) begin
						nx_qm_found = 1'b1;
						nx_qm_pos = pos_q;
					end
					nx_left = left_q - 9'd1;
					if (nx_left == 9'd0) begin
						fin_go = 1'b1;
					end
				end
				default: ;
			endcase
			if (sv_go) begin
				if (nx_run == uri_path_num_q) begin
					nx_uri_vld = 1'b1;
					nx_uri_off = pos_inc;
					nx_uri_len = sv_len;
					nx_qm_found = 1'b0;
					nx_kind = KIND_URI;
				end else if (nx_run == uri_query_num_q) begin
					nx_qry_vld = 1'b1;
					nx_qry_off = pos_inc;
					nx_qry_len = sv_len;
					nx_kind = KIND_QUERY;
				end else begin
					nx_kind = KIND_OTHER;
				end
				nx_left = sv_len;
				if (sv_len == 9'd0) begin
					fin_go = 1'b1;
				end else begin
					nx_phase = PH_OPT_VAL;
				end
			end
			if (fin_go) begin
				nx_opts = opts_q - 4'd1;
				if (nx_opts == 4'd0) begin
					nx_phase = PH_PAYLOAD;
					nx_pstart = pos_inc;
				end else begin
					nx_phase = PH_OPT_HEAD;
				end
			end
		end
	end

	assign c_uri_off = CALC_W'(nx_uri_off);
	assign c_uri_len = CALC_W'(nx_uri_len);
	assign c_qm_pos = CALC_W'(nx_qm_pos);
	assign c_pos = CALC_W'(nx_pos);
	assign c_ps = CALC_W'(nx_pstart);
	assign c_ul = c_qm_pos - c_uri_off;
	assign c_ql = c_uri_len - c_ul - CALC_W'(1);

	always_comb begin
		res = '0;
		res.version = nx_hdr[31:30];
		res.msg_type = nx_hdr[29:28];
		res.option_total = nx_hdr[27:24];
		res.code = nx_hdr[23:16];
		res.transaction_id = nx_hdr[15:0];
		if (nx_too_long) begin
			res.status = ST_TOO_LONG;
		end else if (nx_phase != PH_PAYLOAD) begin
			res.status = ST_TRUNCATED;
		end else begin
			res.status = ST_OK;
		end
		if (nx_uri_vld) begin
			res.uri_offset = c_uri_off[OFF_W-1:0];
			res.uri_len = c_uri_len[OFF_W-1:0];
		end
		if (nx_qry_vld) begin
			res.query_offset = OFF_W'(nx_qry_off);
			res.query_bytes = OFF_W'(nx_qry_len);
		end else if (nx_uri_vld && nx_qm_found) begin
			res.uri_len = c_ul[OFF_W-1:0];
			res.query_offset = OFF_W'(c_qm_pos + CALC_W'(1));
			res.query_bytes = c_ql[OFF_W-1:0];
		end
		if (nx_phase == PH_PAYLOAD && nx_pos > nx_pstart) begin
			res.payload_offset = c_ps[OFF_W-1:0];
			res.payload_bytes = OFF_W'(c_pos - c_ps);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_HEADER;
			hdr_q <= '0;
			opts_q <= '0;
			run_q <= '0;
			left_q <= '0;
			kind_q <= KIND_OTHER;
			uri_vld_q <= 1'b0;
			uri_off_q <= '0;
			uri_len_q <= '0;
			qry_vld_q <= 1'b0;
			qry_off_q <= '0;
			qry_len_q <= '0;
			qm_found_q <= 1'b0;
			qm_pos_q <= '0;
			pstart_q <= '0;
			too_long_q <= 1'b0;
		end else if (advance && last_s1) begin
			pos_q <= '0;
			phase_q <= PH_HEADER;
			hdr_q <= '0;
			opts_q <= '0;
			run_q <= '0;
			left_q <= '0;
			kind_q <= KIND_OTHER;
			uri_vld_q <= 1'b0;
			uri_off_q <= '0;
			uri_len_q <= '0;
			qry_vld_q <= 1'b0;
			qry_off_q <= '0;
			qry_len_q <= '0;
			qm_found_q <= 1'b0;
			qm_pos_q <= '0;
			pstart_q <= '0;
			too_long_q <= 1'b0;
		end else if (advance) begin
			pos_q <= nx_pos;
			phase_q <= nx_phase;
			hdr_q <= nx_hdr;
			opts_q <= nx_opts;
			run_q <= nx_run;
			left_q <= nx_left;
			kind_q <= nx_kind;
			uri_vld_q <= nx_uri_vld;
			uri_off_q <= nx_uri_off;
			uri_len_q <= nx_uri_len;
			qry_vld_q <= nx_qry_vld;
			qry_off_q <= nx_qry_off;
			qry_len_q <= nx_qry_len;
			qm_found_q <= nx_qm_found;
			qm_pos_q <= nx_qm_pos;
			pstart_q <= nx_pstart;
			too_long_q <= nx_too_long;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result <= res;
		end
	end

`ifndef SYNTHESIS
	// The byte counter never runs past the message limit.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_MESSAGE_BYTES))
		else $error("byte position beyond the message limit");

	// The header phase only ever covers the first four bytes.
	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (pos_q < POS_W'(4)))
		else $error("header phase past byte three");

	// An option value phase always has bytes still to skip.
	a_val_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OPT_VAL) |-> (left_q != 9'd0))
		else $error("option value phase with no bytes left");

	// The payload never starts beyond the bytes counted so far.
	a_payload_start: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (pstart_q <= pos_q))
		else $error("payload start beyond byte position");

	// A last byte that leaves the byte register always yields a result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> result_valid)
		else $error("last byte without a result");
`endif

endmodule
